### hdl/jbt_pkg.sv
// Shared types, token and error codes, and literal spelling tables for the JSON tokenizer.
// Depends on nothing; used by hdl/json_byte_tokenizer.sv.
`timescale 1ns / 1ps
`default_nettype none
package jbt_pkg;

	localparam int unsigned FifoDepth = 4;

	// lexer modes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_NUMBER  = 3'd1;
	localparam logic [2:0] MODE_STRING  = 3'd2;
	localparam logic [2:0] MODE_ESCAPE  = 3'd3;
	localparam logic [2:0] MODE_UNICODE = 3'd4;
	localparam logic [2:0] MODE_LITERAL = 3'd5;

	// token kinds
	localparam logic [3:0] KIND_OBJ_BEGIN = 4'd0;
	localparam logic [3:0] KIND_OBJ_END   = 4'd1;
	localparam logic [3:0] KIND_ARR_BEGIN = 4'd2;
	localparam logic [3:0] KIND_ARR_END   = 4'd3;
	localparam logic [3:0] KIND_NUMBER    = 4'd4;
	localparam logic [3:0] KIND_STRING    = 4'd5;
	localparam logic [3:0] KIND_TRUE      = 4'd6;
	localparam logic [3:0] KIND_END       = 4'd9;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
	localparam logic [2:0] ERR_ESCAPE     = 3'd2;
	localparam logic [2:0] ERR_UNTERM     = 3'd3;
	localparam logic [2:0] ERR_LITERAL    = 3'd4;

	// literal kinds
	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] data;
		logic       has;
		logic       last;
		logic [2:0] err;
	} result_t;

	// letter at position pos of a literal; 0 past its end
	function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (kind)
			LIT_FALSE: begin
				case (pos)
					3'd0: ch = "f";
					3'd1: ch = "a";
					3'd2: ch = "l";
					3'd3: ch = "s";
					3'd4: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			LIT_NULL: begin
				case (pos)
					3'd0: ch = "n";
					3'd1: ch = "u";
					3'd2: ch = "l";
					3'd3: ch = "l";
					default: ch = 8'h00;
				endcase
			end
			default: begin
				case (pos)
					3'd0: ch = "t";
					3'd1: ch = "r";
					3'd2: ch = "u";
					3'd3: ch = "e";
					default: ch = 8'h00;
				endcase
			end
		endcase
		return ch;
	endfunction

	function automatic logic [3:0] lit_len(input logic [1:0] kind);
		logic [3:0] len;
		case (kind)
			LIT_FALSE: len = 4'd5;
			default:   len = 4'd4;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

### hdl/json_byte_tokenizer.sv
// JSON byte tokenizer top level: input register, one-step lexer logic, result queue.
// Depends on hdl/jbt_pkg.sv.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | in_byte[7:0], end_of_input
//  out     | out_valid / out_ready| token_kind[3:0], data_byte[7:0], has_data,
//          |                      | last, error_code[2:0]
//
//  An accepted request is held in the input register, then the lexer step
//  writes its zero, one or two results into a four-entry result queue.
//  One request per cycle is sustained while the queue drains at least as fast as
//  results arrive; the queue must hold two free slots before a request is stepped.
//  The first result is visible once the lexer step has written it into the queue.
//  Reset (arst_n low) clears the lexer state, the sticky error and the queue.
//  After an error the block keeps accepting requests and drops them.
//
module json_byte_tokenizer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [3:0]      token_kind,
	output logic [7:0]      data_byte,
	output logic            has_data,
	output logic            last,
	output logic [2:0]      error_code
);

	localparam int unsigned PtrW = $clog2(jbt_pkg::FifoDepth);
	localparam int unsigned CntW = $clog2(jbt_pkg::FifoDepth + 1);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// lexer state
	logic [2:0] mode_q;
	logic [2:0] cnt_q;
	logic [1:0] lkind_q;
	logic       lok_q;
	logic [2:0] err_q;

	// result queue
	jbt_pkg::result_t res_q [jbt_pkg::FifoDepth];
	logic [PtrW-1:0]  head_q;
	logic [PtrW-1:0]  tail_q;
	logic [CntW-1:0]  fill_q;

	logic proc;
	logic pop;

	// step the held request only when two queue slots are free
	assign proc     = valid_s1 && (fill_q <= CntW'(jbt_pkg::FifoDepth - 2));
	assign in_ready = !valid_s1 || proc;
	assign out_valid = (fill_q != '0);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			end_s1  <= end_of_input;
		end
	end

	// ---------------------------------------------------------------
	// lexer step
	// ---------------------------------------------------------------
	logic [7:0] c;
	logic       eoi;

	assign c   = byte_s1;
	assign eoi = end_s1 || (byte_s1 == 8'h00);

	// idle handling of the byte, shared by idle mode and a closed number
	logic             id_emit;
	jbt_pkg::result_t id_res;
	logic [2:0]       id_mode;
	logic [2:0]       id_err;
	logic             id_lit;
	logic [1:0]       id_lkind;

	always_comb begin
		id_emit  = 1'b0;
		id_res   = '{kind: jbt_pkg::KIND_END, data: 8'h00, has: 1'b0, last: 1'b1,
			err: jbt_pkg::ERR_NONE};
		id_mode  = jbt_pkg::MODE_IDLE;
		id_err   = jbt_pkg::ERR_NONE;
		id_lit   = 1'b0;
		id_lkind = jbt_pkg::LIT_TRUE;
		if (eoi) begin
			id_emit = 1'b1;
		end else begin
			case (c)
				"{": begin
					id_emit = 1'b1;
					id_res.kind = jbt_pkg::KIND_OBJ_BEGIN;
				end
				"}": begin
					id_emit = 1'b1;
					id_res.kind = jbt_pkg::KIND_OBJ_END;
				end
				"[": begin
					id_emit = 1'b1;
					id_res.kind = jbt_pkg::KIND_ARR_BEGIN;
				end
				"]": begin
					id_emit = 1'b1;
					id_res.kind = jbt_pkg::KIND_ARR_END;
				end
				":", ",", " ", 8'h0a, 8'h0d: begin
					id_emit = 1'b0;
				end
				"\"": begin
					id_mode = jbt_pkg::MODE_STRING;
				end
				"t": begin
					id_lit = 1'b1;
					id_lkind = jbt_pkg::LIT_TRUE;
					id_mode = jbt_pkg::MODE_LITERAL;
				end
				"f": begin
					id_lit = 1'b1;
					id_lkind = jbt_pkg::LIT_FALSE;
					id_mode = jbt_pkg::MODE_LITERAL;
				end
				"n": begin
					id_lit = 1'b1;
					id_lkind = jbt_pkg::LIT_NULL;
					id_mode = jbt_pkg::MODE_LITERAL;
				end
				default: begin
					id_emit = 1'b1;
					if (c == "-" || (c >= "0" && c <= "9")) begin
						id_mode = jbt_pkg::MODE_NUMBER;
						id_res = '{kind: jbt_pkg::KIND_NUMBER, data: c, has: 1'b1,
							last: 1'b0, err: jbt_pkg::ERR_NONE};
					end else begin
						id_err = jbt_pkg::ERR_UNEXPECTED;
						id_res.err = jbt_pkg::ERR_UNEXPECTED;
					end
				end
			endcase
		end
	end

	// literal compare
	logic [1:0] lk;
	logic [3:0] lpos_nx;
	logic       lmiss;

	assign lk      = (lkind_q == 2'd3) ? jbt_pkg::LIT_TRUE : lkind_q;
	assign lpos_nx = {1'b0, cnt_q} + 4'd1;
	assign lmiss   = ({1'b0, cnt_q} >= jbt_pkg::lit_len(lk)) ||
		(jbt_pkg::lit_char(lk, cnt_q) != c);

	logic [1:0]       n_res;
	jbt_pkg::result_t r0;
	jbt_pkg::result_t r1;
	jbt_pkg::result_t fail_res;
	logic [2:0]       mode_d;
	logic [2:0]       cnt_d;
	logic [1:0]       lkind_d;
	logic             lok_d;
	logic [2:0]       err_d;
	logic [2:0]       uni_nx;
	logic [7:0]       esc_d;
	logic             esc_ok;

	assign uni_nx = cnt_q + 3'd1;

	always_comb begin
		case (c)
			"\"":    begin esc_d = "\"";  esc_ok = 1'b1; end
			"\\":    begin esc_d = "\\";  esc_ok = 1'b1; end
			"/":     begin esc_d = "/";   esc_ok = 1'b1; end
			"b":     begin esc_d = 8'h08; esc_ok = 1'b1; end
			"f":     begin esc_d = 8'h0c; esc_ok = 1'b1; end
			"n":     begin esc_d = 8'h0a; esc_ok = 1'b1; end
			"r":     begin esc_d = 8'h0d; esc_ok = 1'b1; end
			"t":     begin esc_d = 8'h09; esc_ok = 1'b1; end
			default: begin esc_d = 8'h00; esc_ok = 1'b0; end
		endcase
	end

	always_comb begin
		n_res    = 2'd0;
		fail_res = '{kind: jbt_pkg::KIND_END, data: 8'h00, has: 1'b0, last: 1'b1,
			err: jbt_pkg::ERR_NONE};
		r0       = fail_res;
		r1       = fail_res;
		mode_d   = mode_q;
		cnt_d    = cnt_q;
		lkind_d  = lkind_q;
		lok_d    = lok_q;
		err_d    = err_q;
		if (err_q == jbt_pkg::ERR_NONE) begin
			case (mode_q)
				jbt_pkg::MODE_NUMBER: begin
					if (!eoi && ((c >= "0" && c <= "9") || c == "-" || c == "+" ||
						c == "." || c == "e" || c == "E")) begin
						n_res = 2'd1;
						r0 = '{kind: jbt_pkg::KIND_NUMBER, data: c, has: 1'b1,
							last: 1'b0, err: jbt_pkg::ERR_NONE};
					end else if (!eoi && c == " ") begin
						n_res = 2'd0;
					end else begin
						// close the number, then treat the byte as in idle
						r0 = '{kind: jbt_pkg::KIND_NUMBER, data: 8'h00, has: 1'b0,
							last: 1'b1, err: jbt_pkg::ERR_NONE};
						r1 = id_res;
						n_res = id_emit ? 2'd2 : 2'd1;
						mode_d = id_mode;
						err_d = id_err;
						if (id_lit) begin
							lkind_d = id_lkind;
							lok_d = 1'b1;
							cnt_d = 3'd1;
						end
					end
				end
				jbt_pkg::MODE_STRING: begin
					n_res = 2'd1;
					if (eoi) begin
						err_d = jbt_pkg::ERR_UNTERM;
						mode_d = jbt_pkg::MODE_IDLE;
						r0.err = jbt_pkg::ERR_UNTERM;
					end else if (c == "\\") begin
						n_res = 2'd0;
						mode_d = jbt_pkg::MODE_ESCAPE;
					end else if (c == "\"") begin
						mode_d = jbt_pkg::MODE_IDLE;
						r0 = '{kind: jbt_pkg::KIND_STRING, data: 8'h00, has: 1'b0,
							last: 1'b1, err: jbt_pkg::ERR_NONE};
					end else begin
						r0 = '{kind: jbt_pkg::KIND_STRING, data: c, has: 1'b1,
							last: 1'b0, err: jbt_pkg::ERR_NONE};
					end
				end
				jbt_pkg::MODE_ESCAPE: begin
					n_res = 2'd1;
					if (eoi || (!esc_ok && c != "u")) begin
						err_d = jbt_pkg::ERR_ESCAPE;
						mode_d = jbt_pkg::MODE_IDLE;
						r0.err = jbt_pkg::ERR_ESCAPE;
					end else if (c == "u") begin
						n_res = 2'd0;
						cnt_d = 3'd0;
						mode_d = jbt_pkg::MODE_UNICODE;
					end else begin
						mode_d = jbt_pkg::MODE_STRING;
						r0 = '{kind: jbt_pkg::KIND_STRING, data: esc_d, has: 1'b1,
							last: 1'b0, err: jbt_pkg::ERR_NONE};
					end
				end
				jbt_pkg::MODE_UNICODE: begin
					if (eoi) begin
						n_res = 2'd1;
						err_d = jbt_pkg::ERR_UNTERM;
						mode_d = jbt_pkg::MODE_IDLE;
						r0.err = jbt_pkg::ERR_UNTERM;
					end else if (uni_nx >= 3'd4) begin
						cnt_d = 3'd0;
						mode_d = jbt_pkg::MODE_STRING;
					end else begin
						cnt_d = uni_nx;
					end
				end
				jbt_pkg::MODE_LITERAL: begin
					if (eoi) begin
						n_res = 2'd1;
						err_d = jbt_pkg::ERR_LITERAL;
						mode_d = jbt_pkg::MODE_IDLE;
						r0.err = jbt_pkg::ERR_LITERAL;
					end else begin
						if (lmiss) begin
							lok_d = 1'b0;
						end
						cnt_d = lpos_nx[2:0];
						if (lpos_nx >= jbt_pkg::lit_len(lk)) begin
							cnt_d = 3'd0;
							mode_d = jbt_pkg::MODE_IDLE;
							n_res = 2'd1;
							if (!lok_q || lmiss) begin
								err_d = jbt_pkg::ERR_LITERAL;
								r0.err = jbt_pkg::ERR_LITERAL;
							end else begin
								r0.kind = jbt_pkg::KIND_TRUE + {2'b00, lk};
							end
						end
					end
				end
				default: begin
					r0 = id_res;
					n_res = id_emit ? 2'd1 : 2'd0;
					mode_d = id_mode;
					err_d = id_err;
					if (id_lit) begin
						lkind_d = id_lkind;
						lok_d = 1'b1;
						cnt_d = 3'd1;
					end
				end
			endcase
		end
	end

	// advance lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= jbt_pkg::MODE_IDLE;
			cnt_q   <= 3'd0;
			lkind_q <= jbt_pkg::LIT_TRUE;
			lok_q   <= 1'b1;
			err_q   <= jbt_pkg::ERR_NONE;
		end else if (proc) begin
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			lkind_q <= lkind_d;
			lok_q   <= lok_d;
			err_q   <= err_d;
		end
	end

	// ---------------------------------------------------------------
	// result queue: up to two writes, one read per cycle
	// ---------------------------------------------------------------
	logic [PtrW-1:0] tail_p1;
	logic [1:0]      n_wr;

	assign tail_p1 = tail_q + PtrW'(1);
	assign n_wr    = proc ? n_res : 2'd0;

	always_ff @(posedge clk) begin
		if (n_wr != 2'd0) begin
			res_q[tail_q] <= r0;
		end
		if (n_wr == 2'd2) begin
			res_q[tail_p1] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			tail_q <= tail_q + PtrW'(n_wr);
			if (pop) begin
				head_q <= head_q + PtrW'(1);
			end
			fill_q <= fill_q + CntW'(n_wr) - CntW'(pop);
		end
	end

	assign token_kind = res_q[head_q].kind;
	assign data_byte  = res_q[head_q].data;
	assign has_data   = res_q[head_q].has;
	assign last       = res_q[head_q].last;
	assign error_code = res_q[head_q].err;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(jbt_pkg::FifoDepth))
		else $error("result queue overfilled");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != jbt_pkg::ERR_NONE) |-> (n_res == 2'd0))
		else $error("results produced after an error");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != jbt_pkg::ERR_NONE) |=> (err_q == $past(err_q)))
		else $error("sticky error changed");

	a_two_only_number: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && n_res == 2'd2) |-> (mode_q == jbt_pkg::MODE_NUMBER))
		else $error("two results outside a number close");

endmodule
`default_nettype wire

### test/json_byte_tokenizer_tb.sv
// Self-checking testbench for json_byte_tokenizer: a directed table, then random JSON text.
// Depends on hdl/jbt_pkg.sv and hdl/json_byte_tokenizer.sv.
`timescale 1ns / 1ps

module json_byte_tokenizer_tb;
	import jbt_pkg::*;

	// token kinds past KIND_TRUE follow the literal order
	localparam logic [3:0] TOK_NULL  = KIND_TRUE + 4'd2;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam int ITEMS_PER_PHASE = 483;

	// one request of the directed table; typed rows carry their own expected tokens
	typedef struct packed {
		logic [7:0] b;
		logic       e;
		logic       typed;
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} req_row_t;

	localparam result_t R_NONE = '0;
	localparam result_t R_END  = '{KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE};
	localparam result_t R_OBJB = '{KIND_OBJ_BEGIN, 8'h00, 1'b0, 1'b1, ERR_NONE};
	localparam result_t R_ARRB = '{KIND_ARR_BEGIN, 8'h00, 1'b0, 1'b1, ERR_NONE};
	localparam result_t R_NULL = '{TOK_NULL, 8'h00, 1'b0, 1'b1, ERR_NONE};

	localparam int NDIR = 29;
	localparam req_row_t DIR_TAB [NDIR] = '{
		// end flag set: byte is ignored, even a high one
		'{8'hFF, 1'b1, 1'b1, 2'd1, R_END, R_NONE},
		// zero byte counts as end as well
		'{8'h00, 1'b0, 1'b1, 2'd1, R_END, R_NONE},
		'{"[",   1'b0, 1'b1, 2'd1, R_ARRB, R_NONE},
		'{"{",   1'b0, 1'b1, 2'd1, R_OBJB, R_NONE},
		// string: top byte value, escaped newline, unicode skip eating a quote and a
		// backslash, then the closing quote
		'{"\"",  1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{8'hFF, 1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"\\",  1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"n",   1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"\\",  1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"u",   1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"\"",  1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"\\",  1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"x",   1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"0",   1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"\"",  1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		// separator: nothing comes out
		'{":",   1'b0, 1'b1, 2'd0, R_NONE, R_NONE},
		// number with an inner space, closed by a brace in the same step
		'{"-",   1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{" ",   1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"9",   1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"E",   1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"}",   1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		// empty string: closing token only
		'{"\"",  1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"\"",  1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{"n",   1'b0, 1'b1, 2'd0, R_NONE, R_NONE},
		'{"u",   1'b0, 1'b1, 2'd0, R_NONE, R_NONE},
		'{"l",   1'b0, 1'b1, 2'd0, R_NONE, R_NONE},
		'{"l",   1'b0, 1'b1, 2'd1, R_NULL, R_NONE},
		// number closed by an end mark: close and end of stream together
		'{"1",   1'b0, 1'b0, 2'd0, R_NONE, R_NONE},
		'{8'h41, 1'b1, 1'b0, 2'd0, R_NONE, R_NONE}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] token_kind;
	logic [7:0] data_byte;
	logic       has_data;
	logic       last;
	logic [2:0] error_code;

	int send_idle = 0;
	int recv_idle = 0;
	int accepted = 0;
	int bad_fields = 0;

	// tokens the block owes us, oldest first
	result_t token_q[$];

	// lexer state as the block should hold it
	logic [2:0] lx_mode = MODE_IDLE;
	logic [2:0] lx_cnt = 3'd0;
	logic [1:0] lx_kind = LIT_TRUE;
	logic       lx_ok = 1'b1;
	logic [2:0] lx_err = ERR_NONE;

	json_byte_tokenizer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.data_byte    (data_byte),
		.has_data     (has_data),
		.last         (last),
		.error_code   (error_code)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs or loses tokens
	initial begin
		#3_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic string lit_word(input logic [1:0] k);
		case (k)
			LIT_FALSE: return "false";
			LIT_NULL:  return "null";
			default:   return "true";
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		bad_fields++;
		$display("%0t ns: %s", $time, msg);
	endtask

	task automatic emit(input logic [3:0] kind, input logic [7:0] data, input logic has,
			input logic fin, input logic [2:0] err);
		result_t r;
		r.kind = kind;
		r.data = data;
		r.has  = has;
		r.last = fin;
		r.err  = err;
		token_q.push_back(r);
	endtask

	// latch the first error, drop back to idle and report it
	task automatic halt_with(input logic [2:0] code);
		lx_err = code;
		lx_mode = MODE_IDLE;
		emit(KIND_END, 8'h00, 1'b0, 1'b1, code);
	endtask

	// a byte seen between tokens
	task automatic idle_byte(input logic [7:0] c, input logic eom);
		if (eom) begin
			emit(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
		end else begin
			case (c)
				"{": emit(KIND_OBJ_BEGIN, 8'h00, 1'b0, 1'b1, ERR_NONE);
				"}": emit(KIND_OBJ_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
				"[": emit(KIND_ARR_BEGIN, 8'h00, 1'b0, 1'b1, ERR_NONE);
				"]": emit(KIND_ARR_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
				":", ",", " ", CH_LF, CH_CR: ;
				"\"": lx_mode = MODE_STRING;
				"t", "f", "n": begin
					lx_kind = (c == "t") ? LIT_TRUE : (c == "f") ? LIT_FALSE : LIT_NULL;
					lx_ok = 1'b1;
					lx_cnt = 3'd1;
					lx_mode = MODE_LITERAL;
				end
				default: begin
					if (c == "-" || (c >= "0" && c <= "9")) begin
						lx_mode = MODE_NUMBER;
						emit(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
					end else begin
						halt_with(ERR_UNEXPECTED);
					end
				end
			endcase
		end
	endtask

	// advance the expected lexer by one request and queue the tokens it yields
	task automatic lex_step(input logic [7:0] c, input logic e);
		logic       eom;
		logic [7:0] d;
		logic       put_d;
		string      w;
		int         pos;
		eom = e || (c == 8'h00);
		if (lx_err == ERR_NONE) begin
			case (lx_mode)
				MODE_NUMBER: begin
					if (!eom && ((c >= "0" && c <= "9") || c == "-" || c == "+" || c == "." ||
							c == "e" || c == "E")) begin
						emit(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
					end else if (!eom && c == " ") begin
						// spaces inside a number are dropped
					end else begin
						emit(KIND_NUMBER, 8'h00, 1'b0, 1'b1, ERR_NONE);
						lx_mode = MODE_IDLE;
						idle_byte(c, eom);
					end
				end
				MODE_STRING: begin
					if (eom)
						halt_with(ERR_UNTERM);
					else if (c == "\\")
						lx_mode = MODE_ESCAPE;
					else if (c == "\"") begin
						lx_mode = MODE_IDLE;
						emit(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
					end else
						emit(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
				end
				MODE_ESCAPE: begin
					put_d = 1'b1;
					d = c;
					if (eom) begin
						put_d = 1'b0;
						halt_with(ERR_ESCAPE);
					end else begin
						case (c)
							"\"", "\\", "/": d = c;
							"b": d = 8'h08;
							"f": d = 8'h0C;
							"n": d = CH_LF;
							"r": d = CH_CR;
							"t": d = CH_TAB;
							"u": begin
								put_d = 1'b0;
								lx_cnt = 3'd0;
								lx_mode = MODE_UNICODE;
							end
							default: begin
								put_d = 1'b0;
								halt_with(ERR_ESCAPE);
							end
						endcase
					end
					if (put_d) begin
						lx_mode = MODE_STRING;
						emit(KIND_STRING, d, 1'b1, 1'b0, ERR_NONE);
					end
				end
				MODE_UNICODE: begin
					if (eom) begin
						halt_with(ERR_UNTERM);
					end else begin
						lx_cnt = lx_cnt + 3'd1;
						if (lx_cnt >= 3'd4) begin
							lx_cnt = 3'd0;
							lx_mode = MODE_STRING;
						end
					end
				end
				MODE_LITERAL: begin
					w = lit_word(lx_kind);
					pos = lx_cnt;
					if (eom) begin
						halt_with(ERR_LITERAL);
					end else begin
						// compare each letter as it comes; report a miss only once every letter is in
						if (pos >= w.len() || w[pos] != c)
							lx_ok = 1'b0;
						pos++;
						lx_cnt = pos[2:0];
						if (pos >= w.len()) begin
							lx_cnt = 3'd0;
							lx_mode = MODE_IDLE;
							if (!lx_ok)
								halt_with(ERR_LITERAL);
							else
								emit(KIND_TRUE + {2'b00, lx_kind}, 8'h00, 1'b0, 1'b1, ERR_NONE);
						end
					end
				end
				default: begin
					lx_mode = MODE_IDLE;
					idle_byte(c, eom);
				end
			endcase
		end
	endtask

	// Present one request at a falling edge, hold it until accepted, then step the
	// expected lexer. Typed rows replace the predicted tokens with their own.
	task automatic push_request(input req_row_t row);
		int n0;
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= row.b;
		end_of_input <= row.e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		accepted++;
		n0 = token_q.size();
		lex_step(row.b, row.e);
		if (row.typed) begin
			while (token_q.size() > n0)
				void'(token_q.pop_back());
			if (row.n > 0)
				token_q.push_back(row.r0);
			if (row.n > 1)
				token_q.push_back(row.r1);
		end
		@(negedge clk);
	endtask

	task automatic send(input logic [7:0] b, input logic e);
		req_row_t row;
		row = '0;
		row.b = b;
		row.e = e;
		push_request(row);
	endtask

	// One well-formed piece of JSON text with random content. Only pieces that
	// leave the lexer idle or inside a number, so no error is raised here.
	task automatic send_random_fragment();
		int         pick;
		int         len;
		int         i;
		logic [7:0] c;
		string      w;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			w = "{}[]";
			send(w[$urandom_range(0, 3)], 1'b0);
		end else if (pick < 20) begin
			len = $urandom_range(1, 3);
			repeat (len) begin
				case ($urandom_range(0, 4))
					0: c = " ";
					1: c = CH_LF;
					2: c = CH_CR;
					3: c = ":";
					default: c = ",";
				endcase
				send(c, 1'b0);
			end
		end else if (pick < 35) begin
			w = lit_word(2'($urandom_range(0, 2)));
			for (i = 0; i < w.len(); i++)
				send(w[i], 1'b0);
		end else if (pick < 55) begin
			w = "0123456789-+.eE ";
			c = ($urandom_range(0, 3) == 0) ? "-" : w[$urandom_range(0, 9)];
			send(c, 1'b0);
			len = $urandom_range(0, 7);
			repeat (len)
				send(w[$urandom_range(0, w.len() - 1)], 1'b0);
		end else if (pick < 90) begin
			send("\"", 1'b0);
			len = $urandom_range(0, 10);
			repeat (len) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					do
						c = 8'($urandom_range(1, 255));
					while (c == "\"" || c == "\\");
					send(c, 1'b0);
				end else if (pick < 9) begin
					w = "\"\\/bfnrt";
					send("\\", 1'b0);
					send(w[$urandom_range(0, 7)], 1'b0);
				end else begin
					// unicode skip: four bytes dropped unseen, quotes and backslashes too
					send("\\", 1'b0);
					send("u", 1'b0);
					repeat (4) begin
						case ($urandom_range(0, 5))
							0: c = "\"";
							1: c = "\\";
							default: c = 8'($urandom_range(1, 255));
						endcase
						send(c, 1'b0);
					end
				end
			end
			send("\"", 1'b0);
		end else begin
			// end mark, by flag with a random byte or by a zero byte
			if ($urandom_range(0, 1))
				send(8'($urandom_range(0, 255)), 1'b1);
			else
				send(8'h00, 1'b0);
		end
	endtask

	// receiver: stall at random as the current phase asks
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// compare every accepted token with the oldest one owed
	always @(posedge clk) begin : check_tokens
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (token_q.size() == 0) begin
				flag_mismatch($sformatf("token with none owed: kind %0d data %02h err %0d",
					token_kind, data_byte, error_code));
			end else begin
				want = token_q.pop_front();
				if (token_kind !== want.kind)
					flag_mismatch($sformatf("token_kind %0d, want %0d", token_kind, want.kind));
				if (data_byte !== want.data)
					flag_mismatch($sformatf("data_byte %02h, want %02h", data_byte, want.data));
				if (has_data !== want.has)
					flag_mismatch($sformatf("has_data %b, want %b", has_data, want.has));
				if (last !== want.last)
					flag_mismatch($sformatf("last %b, want %b", last, want.last));
				if (error_code !== want.err)
					flag_mismatch($sformatf("error_code %0d, want %0d", error_code, want.err));
			end
		end
	end

	initial begin
		int         i;
		int         ph;
		int         goal;
		logic [7:0] tail_b;
		logic       tail_e;
		logic [2:0] code;
		req_row_t   row;

		// hold reset, then release it between edges
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 13;
		recv_idle = 83;
		for (i = 0; i < NDIR; i++)
			push_request(DIR_TAB[i]);

		// three phases: slow receiver, slow sender, then full rate
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 13;
					recv_idle = 83;
				end
				1: begin
					send_idle = 83;
					recv_idle = 13;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			goal = accepted + ITEMS_PER_PHASE;
			while (accepted < goal)
				send_random_fragment();
			// hold the sender until every owed token is out
			in_valid <= 1'b0;
			while (token_q.size() != 0)
				@(posedge clk);
			@(negedge clk);
		end

		// An error halts the block for good, so only one error case fits in a run.
		// Close any open number first, then pick the case.
		send(",", 1'b0);
		tail_e = 1'b0;
		case ($urandom_range(0, 6))
			0: begin
				// tab or any high byte between tokens
				tail_b = $urandom_range(0, 1) ? CH_TAB : 8'($urandom_range(128, 255));
				code = ERR_UNEXPECTED;
			end
			1: begin
				// end right after a backslash
				send("\"", 1'b0);
				send("\\", 1'b0);
				tail_b = 8'($urandom_range(0, 255));
				tail_e = 1'b1;
				code = ERR_ESCAPE;
			end
			2: begin
				// unknown escape letter
				send("\"", 1'b0);
				send("\\", 1'b0);
				tail_b = "q";
				code = ERR_ESCAPE;
			end
			3: begin
				// zero byte inside a string
				send("\"", 1'b0);
				send("a", 1'b0);
				tail_b = 8'h00;
				code = ERR_UNTERM;
			end
			4: begin
				// end inside a unicode skip
				send("\"", 1'b0);
				send("\\", 1'b0);
				send("u", 1'b0);
				send("1", 1'b0);
				tail_b = 8'($urandom_range(0, 255));
				tail_e = 1'b1;
				code = ERR_UNTERM;
			end
			5: begin
				// wrong letter, reported after the last one
				send("t", 1'b0);
				send("r", 1'b0);
				send("x", 1'b0);
				tail_b = "e";
				code = ERR_LITERAL;
			end
			default: begin
				// end inside a literal
				send("f", 1'b0);
				send("a", 1'b0);
				tail_b = 8'($urandom_range(0, 255));
				tail_e = 1'b1;
				code = ERR_LITERAL;
			end
		endcase
		row = '0;
		row.b = tail_b;
		row.e = tail_e;
		row.typed = 1'b1;
		row.n = 2'd1;
		row.r0 = R_END;
		row.r0.err = code;
		push_request(row);
		// halted: requests are taken and dropped
		repeat (4) begin
			row = '0;
			row.b = 8'($urandom_range(0, 255));
			row.e = 1'($urandom_range(0, 1));
			row.typed = 1'b1;
			push_request(row);
		end
		in_valid <= 1'b0;

		// drain, then watch a little longer for stray tokens
		for (i = 0; i < 5000 && token_q.size() != 0; i++)
			@(posedge clk);
		if (token_q.size() != 0)
			flag_mismatch($sformatf("%0d tokens never came out", token_q.size()));
		repeat (20) @(posedge clk);

		if (bad_fields == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
hdl/jbt_pkg.sv
hdl/json_byte_tokenizer.sv
test/json_byte_tokenizer_tb.sv
